/* design/hids_pkg.sv */
package hids_pkg;

  // Operation codes
  localparam logic [1:0] OP_LOOKUP      = 2'd0;
  localparam logic [1:0] OP_ALLOCATE    = 2'd1;
  localparam logic [1:0] OP_RELEASE     = 2'd2;
  localparam logic [1:0] OP_RELEASE_ALL = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BOUND     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned IDX_W = 7;

  typedef logic [KEY_W-1:0] key_t;

  // One stored slot
  typedef struct packed {
    logic used;
    logic dir;
    key_t key;
  } slot_word_t;

  // Scan summary handed from the compare unit to the sequencer
  typedef struct packed {
    logic found;
    logic found_dir;
    logic free_found;
  } scan_res_t;

endpackage

/* design/handle_id_slot_table.sv */
// Channel  Direction  Handshake           Beat
// in       input      in_valid/in_stall   opcode, handle_key, directory_flag
// out      output     out_valid/out_stall status, hit, slot_index, entry_directory
//
// Each item scans every slot once through one key comparator fed by the slot
// memory read port. No new item is taken until the previous one has left the
// finish step; in_stall stays high through scan, drain and finish.
// Release-all adds a clearing sweep, one slot per cycle.
// After reset the same sweep runs before in_stall drops.
// A new item is taken while the previous result waits; the finish step holds
// until the output register is free.
module handle_id_slot_table #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  hids_pkg::key_t        handle_key,
  input  logic                  directory_flag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic                  hit,
  output logic [hids_pkg::IDX_W-1:0] slot_index,
  output logic                  entry_directory
);
  import hids_pkg::*;

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t      state;
  logic [AW-1:0] cnt;
  logic [1:0]  op;
  key_t        key;
  logic        dirf;
  logic        rd_pending;
  logic [AW-1:0] rd_idx;

  logic        accept;
  logic        out_free;
  logic        finish;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  slot_word_t  wr_data;
  slot_word_t  rd_data;
  scan_res_t   res;
  logic [AW-1:0] found_idx;
  logic [AW-1:0] free_idx;

  logic [1:0]  status_next;
  logic [AW-1:0] idx_next;
  logic        edir_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == S_FINISH) && out_free;

  hids_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state == S_SCAN),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  hids_scan #(
    .AW (AW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .data_valid (rd_pending),
    .data_idx   (rd_idx),
    .data       (rd_data),
    .key        (key),
    .res        (res),
    .found_idx  (found_idx),
    .free_idx   (free_idx)
  );

  // Result of the finished scan
  always_comb begin
    status_next = ST_OK;
    idx_next    = res.found ? found_idx : '0;
    edir_next   = res.found ? res.found_dir : 1'b0;
    case (op)
      OP_LOOKUP: begin
        if (!res.found) status_next = ST_NOT_FOUND;
      end
      OP_ALLOCATE: begin
        if (res.found) begin
          status_next = ST_BOUND;
        end else if (res.free_found) begin
          idx_next  = free_idx;
          edir_next = dirf;
        end else begin
          status_next = ST_FULL;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Slot memory writes: clearing sweep, bind or release
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (finish) begin
      case (op)
        OP_ALLOCATE: begin
          wr_en   = !res.found && res.free_found;
          wr_addr = free_idx;
          wr_data = '{used: 1'b1, dir: dirf, key: key};
        end
        OP_RELEASE: begin
          wr_en   = res.found;
          wr_addr = found_idx;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= (state == S_SCAN);
      rd_idx     <= cnt;
      // a new result replaces the one taken at this edge
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op    <= opcode;
            key   <= handle_key;
            dirf  <= directory_flag;
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            status          <= status_next;
            hit             <= res.found;
            slot_index      <= IDX_W'(idx_next);
            entry_directory <= edir_next;
            cnt             <= '0;
            state           <= (op == OP_RELEASE_ALL) ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/hids_slot_mem.sv */
module hids_slot_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  hids_pkg::slot_word_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output hids_pkg::slot_word_t rd_data
);
  import hids_pkg::*;

  slot_word_t mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/hids_scan.sv */
module hids_scan #(
  parameter int unsigned AW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 data_valid,
  input  logic [AW-1:0]        data_idx,
  input  hids_pkg::slot_word_t data,
  input  hids_pkg::key_t       key,
  output hids_pkg::scan_res_t  res,
  output logic [AW-1:0]        found_idx,
  output logic [AW-1:0]        free_idx
);
  import hids_pkg::*;

  logic match;
  logic is_free;

  // Shared key comparator, one slot per beat of the scan
  assign match   = data_valid && data.used && (data.key == key);
  assign is_free = data_valid && !data.used;

  // Keep the lowest matching slot and the lowest free slot
  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.found      <= 1'b0;
      res.found_dir  <= 1'b0;
      res.free_found <= 1'b0;
      found_idx      <= '0;
      free_idx       <= '0;
    end else begin
      if (match && !res.found) begin
        res.found     <= 1'b1;
        res.found_dir <= data.dir;
        found_idx     <= data_idx;
      end
      if (is_free && !res.free_found) begin
        res.free_found <= 1'b1;
        free_idx       <= data_idx;
      end
    end
  end

endmodule

/* bench/handle_id_slot_table_check.sv */
// Watches both channels of the slot table, keeps its own copy of the table,
// works out the result of every accepted input beat and checks the results
// in order against it.
module handle_id_slot_table_check #(
  parameter int unsigned SLOTS = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 opcode,
  input  hids_pkg::key_t             handle_key,
  input  logic                       directory_flag,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 status,
  input  logic                       hit,
  input  logic [hids_pkg::IDX_W-1:0] slot_index,
  input  logic                       entry_directory,
  output int                         errors,
  output int                         pending
);
  import hids_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic             dir;
  } slot_result_t;

  // Shadow copy of the table
  logic bound [SLOTS];
  key_t bound_key [SLOTS];
  logic bound_dir [SLOTS];

  slot_result_t due_results[$];
  slot_result_t want;
  int error_total = 0;

  assign errors = error_total;

  task automatic report_mismatch(input string field, input int got, input int wanted);
    error_total++;
    $display("mismatch at %0t: %s got %0d, want %0d", $time, field, got, wanted);
  endtask

  // Apply one operation to the shadow table and return its result
  function automatic slot_result_t table_step(input logic [1:0] op, input key_t key,
                                              input logic dirf);
    slot_result_t r;
    int found;
    r = '0;
    found = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (bound[i] && bound_key[i] == key) begin
        found = i;
        break;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      r.slot = IDX_W'(found);
      r.dir = bound_dir[found];
    end
    case (op)
      OP_LOOKUP: begin
        if (found < 0) r.status = ST_NOT_FOUND;
      end
      OP_ALLOCATE: begin
        if (found >= 0) begin
          r.status = ST_BOUND;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!bound[i]) begin
              bound[i] = 1'b1;
              bound_key[i] = key;
              bound_dir[i] = dirf;
              r.status = ST_OK;
              r.slot = IDX_W'(i);
              r.dir = dirf;
              break;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (found >= 0) bound[found] = 1'b0;
      end
      default: begin
        // release all: result reports the lookup made before clearing
        for (int i = 0; i < SLOTS; i++) bound[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Results are taken before new beats at the same edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) bound[i] = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due, status", int'(status), 0);
        end else begin
          want = due_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
          if (hit !== want.hit) report_mismatch("hit", int'(hit), int'(want.hit));
          if (slot_index !== want.slot)
            report_mismatch("slot_index", int'(slot_index), int'(want.slot));
          if (entry_directory !== want.dir)
            report_mismatch("entry_directory", int'(entry_directory), int'(want.dir));
        end
      end
      if (in_valid && !in_stall)
        due_results.push_back(table_step(opcode, handle_key, directory_flag));
    end
    pending <= due_results.size();
  end

endmodule

/* bench/handle_id_slot_table_test.sv */
module handle_id_slot_table_test;
  import hids_pkg::*;

  localparam int BEAT_TARGET = 1800;
  localparam int IDLE_LIMIT = 4000;   // cycles with no beat on either channel
  localparam int DRAIN_CYCLES = 300;  // scan plus clearing sweep, with margin

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       opcode;
  key_t             handle_key;
  logic             directory_flag;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       status;
  logic             hit;
  logic [IDX_W-1:0] slot_index;
  logic             entry_directory;
  int               errors;
  int               pending;

  int   beats_sent = 0;
  bit   in_steady = 1'b0;
  bit   out_steady = 1'b0;
  key_t recent_keys[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  handle_id_slot_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .handle_key(handle_key), .directory_flag(directory_flag),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .hit(hit), .slot_index(slot_index),
    .entry_directory(entry_directory)
  );

  handle_id_slot_table_check checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .handle_key(handle_key), .directory_flag(directory_flag),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .hit(hit), .slot_index(slot_index),
    .entry_directory(entry_directory),
    .errors(errors), .pending(pending)
  );

  // Drive one beat after a random gap; valid stays high across back-to-back beats
  task automatic send_beat(input logic [1:0] op, input key_t key, input logic dirf);
    int gap;
    if ($urandom_range(0, 63) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    handle_key <= key;
    directory_flag <= dirf;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (op == OP_ALLOCATE) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
  endtask

  // Mostly keys seen before, so that hits are common
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h0000_0001;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_LOOKUP;
    if (r < 65) return OP_ALLOCATE;
    if (r < 97) return OP_RELEASE;
    return OP_RELEASE_ALL;
  endfunction

  // Fill the table close to or past full, punch holes, refill them
  task automatic fill_run();
    int n;
    n = $urandom_range(120, 140);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) send_beat(OP_LOOKUP, pick_key(), 1'b0);
      send_beat(OP_ALLOCATE, $urandom, 1'($urandom_range(0, 1)));
    end
    repeat (3) send_beat(OP_ALLOCATE, $urandom, 1'($urandom_range(0, 1)));
    repeat (4) send_beat(OP_RELEASE, pick_key(), 1'b0);
    repeat (4) send_beat(OP_ALLOCATE, $urandom, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1) == 0) send_beat(OP_RELEASE_ALL, pick_key(), 1'b0);
  endtask

  // Result side: random stall before each result, with runs of none
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 63) == 0) out_steady = !out_steady;
      hold = out_steady ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin
    int mode;
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= OP_LOOKUP;
    handle_key <= '0;
    directory_flag <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: misses, binds, duplicate bind, release, lowest free reuse
    send_beat(OP_LOOKUP, 32'h0000_0000, 1'b1);
    send_beat(OP_RELEASE, 32'hFFFF_FFFF, 1'b1);
    send_beat(OP_ALLOCATE, 32'h0000_0000, 1'b0);
    send_beat(OP_ALLOCATE, 32'hFFFF_FFFF, 1'b1);
    send_beat(OP_ALLOCATE, 32'h0000_0000, 1'b1);
    send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    send_beat(OP_LOOKUP, 32'h0000_0000, 1'b0);
    send_beat(OP_RELEASE, 32'h0000_0000, 1'b0);
    send_beat(OP_LOOKUP, 32'h0000_0000, 1'b0);
    send_beat(OP_ALLOCATE, 32'h5A5A_5A5A, 1'b1);
    send_beat(OP_ALLOCATE, 32'hA5A5_A5A5, 1'b0);
    send_beat(OP_RELEASE, 32'h5A5A_5A5A, 1'b0);
    send_beat(OP_ALLOCATE, 32'h8000_0001, 1'b1);
    // release all of a bound key reports it, then of an unknown key
    send_beat(OP_RELEASE_ALL, 32'hFFFF_FFFF, 1'b0);
    send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    send_beat(OP_LOOKUP, 32'hA5A5_A5A5, 1'b0);
    send_beat(OP_RELEASE_ALL, 32'h1234_5678, 1'b1);
    send_beat(OP_ALLOCATE, 32'h7FFF_FFFF, 1'b1);
    send_beat(OP_RELEASE, 32'h7FFF_FFFF, 1'b1);

    // a fill run comes first, then a mix of runs
    fill_run();
    while (beats_sent < BEAT_TARGET) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        fill_run();
      end else if (mode < 9) begin
        repeat (40) send_beat(pick_op(), pick_key(), 1'($urandom_range(0, 1)));
      end else begin
        repeat (10) send_beat(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog on cycles with no beat accepted on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
